>>> design/i2cram_pkg.sv
package i2cram_pkg;

	// Register defaults and register indexes on the configuration channel.
	localparam logic [15:0] HALF_PERIOD_RST = 16'd10;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1024;
	localparam int          CFG_IDX_W       = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

	// Depth of the request queue between the front and the bus engine.
	localparam int QUEUE_DEPTH = 4;

	// Stream widths.
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;

	// Programme lengths and the index of the last bit step of a byte.
	localparam logic [3:0] PROG_LEN_WRITE = 4'd9;
	localparam logic [3:0] PROG_LEN_READ  = 4'd12;
	localparam logic [3:0] LAST_BIT       = 4'd8;

	typedef enum logic [3:0] {
		OP_INIT  = 4'd0,
		OP_START = 4'd1,
		OP_WDEV  = 4'd2,
		OP_WREG  = 4'd3,
		OP_WDAT  = 4'd4,
		OP_WDEV1 = 4'd5,
		OP_ACK   = 4'd6,
		OP_READ  = 4'd7,
		OP_NACK  = 4'd8,
		OP_STOP  = 4'd9
	} op_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_READ  = 1'b1
	} mode_t;

	// One request as it waits in the queue.
	typedef struct packed {
		logic       start_req;
		logic       mode;
		logic [7:0] device;
		logic [7:0] reg_addr;
		logic [7:0] wdata;
		logic       sda_in;
	} item_t;

	// Register file contents handed to the engine.
	typedef struct packed {
		logic [15:0] half_period;
		logic [15:0] ack_timeout;
	} cfg_t;

	// Levels and shifter contents on entry to a bus step.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] shift;
	} step_t;

	// Bus step at a given programme position (phase is position plus one).
	function automatic op_t cur_op(input logic [3:0] phase, input logic mode);
		op_t op;
		op = OP_STOP;
		case (phase)
			4'd1:  op = OP_INIT;
			4'd2:  op = OP_START;
			4'd3:  op = OP_WDEV;
			4'd4:  op = OP_ACK;
			4'd5:  op = OP_WREG;
			4'd6:  op = OP_ACK;
			4'd7:  op = (mode == MODE_READ) ? OP_START : OP_WDAT;
			4'd8:  op = (mode == MODE_READ) ? OP_WDEV1 : OP_ACK;
			4'd9:  op = (mode == MODE_READ) ? OP_ACK : OP_STOP;
			4'd10: op = (mode == MODE_READ) ? OP_READ : OP_STOP;
			4'd11: op = (mode == MODE_READ) ? OP_NACK : OP_STOP;
			default: op = OP_STOP;
		endcase
		return op;
	endfunction

	function automatic logic is_write_op(input op_t op);
		return (op == OP_WDEV) || (op == OP_WREG) || (op == OP_WDAT) || (op == OP_WDEV1);
	endfunction

	// Number of sub-steps in one bit of the given step.
	function automatic logic [1:0] subs_of(input op_t op, input logic [3:0] bit_cnt);
		logic [1:0] n;
		n = 2'd3;
		if (op == OP_INIT) begin
			n = 2'd1;
		end else if (op == OP_READ) begin
			n = 2'd2;
		end else if (is_write_op(op)) begin
			n = (bit_cnt < LAST_BIT) ? 2'd3 : 2'd2;
		end
		return n;
	endfunction

	function automatic logic [3:0] last_bit(input op_t op);
		return (is_write_op(op) || (op == OP_READ)) ? LAST_BIT : 4'd0;
	endfunction

	function automatic logic [3:0] prog_len(input logic mode);
		return (mode == MODE_READ) ? PROG_LEN_READ : PROG_LEN_WRITE;
	endfunction

endpackage

>>> design/i2cram_front.sv
module i2cram_front #(
	parameter int DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [i2cram_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [i2cram_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                            q_valid,
	output i2cram_pkg::item_t               q_item,
	input  logic                            q_pop
);
	import i2cram_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            in_item;
	logic             push;

	// Unpack the stream request into its fields.
	always_comb begin
		in_item.start_req = s_tuser[0];
		in_item.mode      = s_tuser[1];
		in_item.device    = s_tdata[7:0];
		in_item.reg_addr  = s_tdata[15:8];
		in_item.wdata     = s_tdata[23:16];
		in_item.sda_in    = s_tdata[24];
	end

	assign s_tready = (count_q != CNT_W'(DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/i2cram_engine.sv
module i2cram_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  i2cram_pkg::cfg_t                cfg,
	input  logic                            q_valid,
	input  i2cram_pkg::item_t               q_item,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [i2cram_pkg::M_TDATA_W-1:0] m_tdata
);
	import i2cram_pkg::*;

	logic [3:0]  phase_q, ph_n;
	logic [3:0]  bit_count_q, bc_n;
	logic [1:0]  sub_q, sb_n;
	logic [15:0] tick_timer_q, tt_n;
	logic [7:0]  shift_reg_q, sh_n;
	logic        held_mode_q, mode_n;
	logic [7:0]  held_device_q, dev_n;
	logic [7:0]  held_reg_q, reg_n;
	logic [7:0]  held_data_q, dat_n;
	logic [7:0]  read_byte_q, rbyte_n;
	logic        scl_level_q, scl_n;
	logic        sda_level_q, sda_n;

	logic [15:0] hp_c, at_c;
	op_t         op_c;
	logic        drv_c, ended_c, done_c;
	logic        res_scl, res_sda, res_drv, res_busy;
	step_t       entry_c;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_q;

	// Bus levels and shifter on entry to a step.
	function automatic step_t enter_step(
		input op_t        op,
		input logic [1:0] sub,
		input logic [3:0] bit_cnt,
		input logic [7:0] shift,
		input logic [7:0] dev,
		input logic [7:0] rega,
		input logic [7:0] dat,
		input logic       scl,
		input logic       sda
	);
		step_t s;
		s.scl   = scl;
		s.sda   = sda;
		s.shift = shift;
		if (op == OP_INIT) begin
			s.scl = 1'b1;
			s.sda = 1'b1;
		end else if (op == OP_START) begin
			if (sub == 2'd0) s.sda = 1'b1;
			else if (sub == 2'd1) s.scl = 1'b1;
			else s.sda = 1'b0;
		end else if (is_write_op(op)) begin
			if (bit_cnt == 4'd0 && sub == 2'd0) begin
				case (op)
					OP_WDEV: s.shift = dev;
					OP_WREG: s.shift = rega;
					OP_WDAT: s.shift = dat;
					default: s.shift = dev + 8'd1;
				endcase
			end
			if (sub == 2'd0) begin
				s.scl = 1'b0;
			end else if (sub == 2'd1) begin
				if (bit_cnt < LAST_BIT) begin
					s.sda   = s.shift[7];
					s.shift = {s.shift[6:0], 1'b0};
				end else begin
					s.sda = 1'b1;
				end
			end else begin
				s.scl = 1'b1;
			end
		end else if (op == OP_ACK) begin
			if (sub == 2'd0) s.scl = 1'b1;
			else if (sub == 2'd2) s.scl = 1'b0;
		end else if (op == OP_READ) begin
			if (bit_cnt == 4'd0) begin
				if (sub == 2'd0) s.scl = 1'b0;
				else s.sda = 1'b1;
			end else begin
				s.scl = (sub == 2'd0);
			end
		end else if (op == OP_NACK) begin
			if (sub == 2'd0) begin
				s.sda = 1'b1;
				s.scl = 1'b1;
			end else if (sub == 2'd1) begin
				s.scl = 1'b0;
			end else begin
				s.sda = 1'b1;
			end
		end else begin
			if (sub == 2'd0) s.sda = 1'b0;
			else if (sub == 2'd1) s.scl = 1'b1;
			else s.sda = 1'b1;
		end
		return s;
	endfunction

	assign hp_c = (cfg.half_period == '0) ? 16'd1 : cfg.half_period;
	assign at_c = (cfg.ack_timeout == '0) ? 16'd1 : cfg.ack_timeout;

	assign q_pop = q_valid && (!out_valid_q || m_tready);

	always_comb begin
		ph_n    = phase_q;
		bc_n    = bit_count_q;
		sb_n    = sub_q;
		tt_n    = tick_timer_q;
		sh_n    = shift_reg_q;
		mode_n  = held_mode_q;
		dev_n   = held_device_q;
		reg_n   = held_reg_q;
		dat_n   = held_data_q;
		rbyte_n = read_byte_q;
		scl_n   = scl_level_q;
		sda_n   = sda_level_q;
		done_c  = 1'b0;
		ended_c = 1'b0;
		entry_c = '0;

		if (ph_n == 4'd0 && q_item.start_req) begin
			mode_n = q_item.mode;
			dev_n  = q_item.device;
			reg_n  = q_item.reg_addr;
			dat_n  = q_item.wdata;
			ph_n   = 4'd1;
			bc_n   = 4'd0;
			sb_n   = 2'd0;
			tt_n   = '0;
			scl_n  = 1'b1;
			sda_n  = 1'b1;
		end

		op_c  = cur_op(ph_n, mode_n);
		drv_c = (op_c != OP_ACK) && !(op_c == OP_READ && bc_n != 4'd0);

		// Levels seen on this tick are those held before the step advances.
		res_scl  = scl_n;
		res_sda  = (ph_n == 4'd0 || drv_c) ? sda_n : 1'b1;
		res_drv  = (ph_n == 4'd0) ? 1'b1 : drv_c;
		res_busy = (ph_n != 4'd0);

		if (ph_n != 4'd0) begin
			if (op_c == OP_ACK && sb_n == 2'd1) begin
				ended_c = !q_item.sda_in || (({1'b0, tt_n} + 17'd1) >= {1'b0, at_c});
			end else begin
				ended_c = ({1'b0, tt_n} + 17'd1) >= {1'b0, hp_c};
			end

			if (!ended_c) begin
				tt_n = tt_n + 16'd1;
			end else begin
				if (op_c == OP_READ && bc_n != 4'd0 && sb_n == 2'd0) begin
					sh_n = {sh_n[6:0], q_item.sda_in};
					if (bc_n == LAST_BIT) begin
						rbyte_n = sh_n;
					end
				end
				sb_n = sb_n + 2'd1;
				if (sb_n >= subs_of(op_c, bc_n)) begin
					sb_n = 2'd0;
					bc_n = bc_n + 4'd1;
					if (bc_n > last_bit(op_c)) begin
						bc_n = 4'd0;
						ph_n = ph_n + 4'd1;
					end
				end
				if (ph_n > prog_len(mode_n)) begin
					ph_n   = 4'd0;
					bc_n   = 4'd0;
					sb_n   = 2'd0;
					tt_n   = '0;
					done_c = 1'b1;
				end else begin
					tt_n    = '0;
					entry_c = enter_step(cur_op(ph_n, mode_n), sb_n, bc_n, sh_n,
						dev_n, reg_n, dat_n, scl_n, sda_n);
					scl_n   = entry_c.scl;
					sda_n   = entry_c.sda;
					sh_n    = entry_c.shift;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= 4'd0;
			bit_count_q   <= 4'd0;
			sub_q         <= 2'd0;
			tick_timer_q  <= '0;
			shift_reg_q   <= '0;
			held_mode_q   <= 1'b0;
			held_device_q <= '0;
			held_reg_q    <= '0;
			held_data_q   <= '0;
			read_byte_q   <= '0;
			scl_level_q   <= 1'b1;
			sda_level_q   <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q       <= ph_n;
				bit_count_q   <= bc_n;
				sub_q         <= sb_n;
				tick_timer_q  <= tt_n;
				shift_reg_q   <= sh_n;
				held_mode_q   <= mode_n;
				held_device_q <= dev_n;
				held_reg_q    <= reg_n;
				held_data_q   <= dat_n;
				read_byte_q   <= rbyte_n;
				scl_level_q   <= scl_n;
				sda_level_q   <= sda_n;
				out_valid_q   <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= {3'b000, rbyte_n, done_c, res_busy, res_drv, res_sda, res_scl};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && done_c |=> phase_q == 4'd0 && bit_count_q == 4'd0 && sub_q == 2'd0)
		else $error("transaction completed but the engine did not return to idle");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= prog_len(held_mode_q))
		else $error("programme position beyond the end of the programme");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= LAST_BIT && sub_q != 2'd3)
		else $error("bit or sub-step counter out of range");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q[4] |-> out_q[3])
		else $error("done reported outside a transaction");

	a_idle_drives: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && phase_q == 4'd0 && !q_item.start_req |=> out_q[2] && !out_q[3])
		else $error("idle tick did not drive SDA or reported busy");

endmodule

>>> design/i2c_register_access_master_unit.sv
// Register-access I2C master, advanced by one bus tick per request.
// Each request on the s_ stream is one tick: it carries the SDA level sampled
// on that tick and, while the engine is idle, may start a register write or a
// register read. Every request yields exactly one result on the m_ stream with
// the SCL level, the SDA level and drive enable, busy and done flags and the
// byte returned by the last completed read.
// The two configuration registers (half period and acknowledge timeout) are
// written through the cfg_ channel, which is always ready; write them only
// while no transaction is running and the result stream has drained.
// A request is written into the queue; when the engine pops it, its result is
// loaded into the output register, which drives m_tvalid.
// Throughput: one request per cycle while the result stream is not stalled;
// the engine steps its bus state once per request in combinational step logic.
// A request queue of QUEUE_DEPTH entries sits between the front and the
// engine. When m_tready is low the result holds in its output register, the
// queue fills, and s_tready falls once it is full.
// Reset clears the queue, returns the engine to idle with SCL and SDA high and
// restores the registers to a half period of 10 and a timeout of 1024 ticks.
module i2c_register_access_master_unit #(
	parameter int QUEUE_DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// device[7:0], reg_addr[15:8], wdata[23:16], sda_in[24], zero[31:25]
	input  logic [i2cram_pkg::S_TDATA_W-1:0] s_tdata,
	// start_req[0], mode[1]
	input  logic [i2cram_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], rdata[12:5],
	// zero[15:13]
	output logic [i2cram_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [i2cram_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data
);
	import i2cram_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// The register file accepts a write on every cycle; indexes that name no
	// register are accepted and ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HALF_PERIOD_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period <= cfg_data;
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front takes tick requests and queues them for the engine.
	i2cram_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// The engine steps the bus programme once per queued tick.
	i2cram_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
